/* rtl/csrs_pkg.sv */
// Shared codes, field widths and controller/datapath interface types for the read splitter.
package csrs_pkg;

	localparam int OP_W     = 2;
	localparam int SIZE_W   = 48;
	localparam int POS_W    = 48;
	localparam int LEN_W    = 32;
	localparam int SIDX_W   = 4;
	localparam int STATUS_W = 2;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_PAD_W  = OUT_DATA_W - (SIDX_W + POS_W + 2 * LEN_W);

	// request kinds
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic capture;
		logic clear;
		logic append;
		logic emit_blank;
		logic clip;
		logic seg_step;
		logic emit_err;
	} csrs_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            len_zero;
		logic            table_full;
		logic            table_empty;
		logic            seg_nonempty;
		logic            seg_last;
		logic            scan_done;
		logic            out_free;
	} csrs_stat_t;

endpackage

/* rtl/csrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csrs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/csrs_ctrl.sv */
// Controller state machine: decodes requests and sequences the range table scan.
module csrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csrs_pkg::csrs_stat_t stat,
	output csrs_pkg::csrs_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_APPEND = 8'b0000_0100,
		S_BLANK  = 8'b0000_1000,
		S_ADDR   = 8'b0001_0000,
		S_CLIP   = 8'b0010_0000,
		S_SEG    = 8'b0100_0000,
		S_ERR    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					csrs_pkg::OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
					csrs_pkg::OP_APPEND: begin
						state_d = stat.table_full ? S_BLANK : S_APPEND;
					end
					csrs_pkg::OP_READ: begin
						if (stat.len_zero) begin
							state_d = S_BLANK;
						end else if (stat.table_empty) begin
							state_d = S_ERR;
						end else begin
							state_d = S_ADDR;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_APPEND: begin
				if (stat.out_free) begin
					cmd.append = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_BLANK: begin
				if (stat.out_free) begin
					cmd.emit_blank = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_ADDR: state_d = S_CLIP;
			S_CLIP: begin
				cmd.clip = 1'b1;
				state_d  = S_SEG;
			end
			S_SEG: begin
				// empty ranges are skipped without waiting for the output slot
				if (!stat.seg_nonempty || stat.out_free) begin
					cmd.seg_step = 1'b1;
					if (stat.seg_nonempty && stat.seg_last) begin
						state_d = S_IDLE;
					end else if (stat.scan_done) begin
						state_d = S_ERR;
					end else begin
						state_d = S_ADDR;
					end
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_capture_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_DECODE)
		else $error("captured request not decoded");

	a_last_seg_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seg_step && stat.seg_nonempty && stat.seg_last) |=> state_q == S_IDLE)
		else $error("scan continued past the last segment");

endmodule

/* rtl/csrs_dpath.sv */
// Datapath: request registers, range table, segment clipping and output register.
module csrs_dpath #(
	parameter int MAX_STREAMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csrs_pkg::csrs_cmd_t                 cmd,
	output csrs_pkg::csrs_stat_t                stat,
	input  logic [csrs_pkg::OP_W-1:0]           in_op,
	input  logic [csrs_pkg::SIZE_W-1:0]         in_stream_size,
	input  logic [csrs_pkg::POS_W-1:0]          in_read_pos,
	input  logic [csrs_pkg::LEN_W-1:0]          in_read_len,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [csrs_pkg::OUT_DATA_W-1:0]     seg_data,
	output logic                                out_last,
	output logic [csrs_pkg::STATUS_W-1:0]       out_status
);

	localparam int CNT_W = $clog2(MAX_STREAMS + 1);
	localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int PW    = csrs_pkg::POS_W;
	localparam int LW    = csrs_pkg::LEN_W;

	logic [csrs_pkg::OP_W-1:0]   op_q;
	logic [csrs_pkg::SIZE_W-1:0] size_q;
	logic [PW-1:0]               pos_q;
	logic [LW-1:0]               len_q;
	logic [PW:0]                 stop_q;
	logic [CNT_W-1:0]            count_q;
	logic [PW-1:0]               total_q;
	logic [CNT_W-1:0]            idx_q;
	logic [PW-1:0]               prev_q;
	logic [PW-1:0]               a_q;
	logic [PW-1:0]               b_q;
	logic [PW-1:0]               end_q;
	logic                        seg_last_q;

	logic [PW-1:0]               rd_end;
	logic [PW:0]                 sum;
	logic [PW-1:0]               new_total;
	logic [LW-1:0]               done;
	logic                        load;

	logic                        o_valid_q;
	logic [csrs_pkg::SIDX_W-1:0] o_sidx_q;
	logic [PW-1:0]               o_local_q;
	logic [LW-1:0]               o_dest_q;
	logic [LW-1:0]               o_len_q;
	logic                        o_last_q;
	logic [csrs_pkg::STATUS_W-1:0] o_status_q;

	csrs_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_STREAMS)
	) u_range_end (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (new_total),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_end)
	);

	// running total saturates at the largest 48-bit position
	assign sum       = {1'b0, total_q} + {1'b0, size_q};
	assign new_total = sum[PW] ? '1 : sum[PW-1:0];
	assign done      = (total_q > pos_q) ? LW'(total_q - pos_q) : '0;

	assign load = cmd.append | cmd.emit_blank | cmd.emit_err
		| (cmd.seg_step & stat.seg_nonempty);

	always_comb begin
		stat.op           = op_q;
		stat.len_zero     = (len_q == '0);
		stat.table_full   = (count_q == CNT_W'(MAX_STREAMS));
		stat.table_empty  = (count_q == '0);
		stat.seg_nonempty = (a_q < b_q);
		stat.seg_last     = seg_last_q;
		stat.scan_done    = (CNT_W'(idx_q + CNT_W'(1)) == count_q);
		stat.out_free     = !o_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				total_q <= '0;
			end else if (cmd.append) begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
				total_q <= new_total;
			end
			if (load) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			size_q <= in_stream_size;
			pos_q  <= in_read_pos;
			len_q  <= in_read_len;
			stop_q <= {1'b0, in_read_pos} + {{(PW + 1 - LW){1'b0}}, in_read_len};
			idx_q  <= '0;
			prev_q <= '0;
		end
		if (cmd.clip) begin
			a_q        <= (pos_q > prev_q) ? pos_q : prev_q;
			b_q        <= (stop_q < {1'b0, rd_end}) ? stop_q[PW-1:0] : rd_end;
			seg_last_q <= (stop_q <= {1'b0, rd_end});
			end_q      <= rd_end;
		end
		if (cmd.seg_step) begin
			idx_q  <= CNT_W'(idx_q + CNT_W'(1));
			prev_q <= end_q;
		end

		if (cmd.emit_blank) begin
			o_sidx_q   <= '0;
			o_local_q  <= '0;
			o_dest_q   <= '0;
			o_len_q    <= '0;
			o_last_q   <= 1'b1;
			o_status_q <= (op_q == csrs_pkg::OP_APPEND) ? csrs_pkg::ST_FULL : csrs_pkg::ST_OK;
		end else if (cmd.append) begin
			o_sidx_q   <= csrs_pkg::SIDX_W'(count_q);
			o_local_q  <= '0;
			o_dest_q   <= '0;
			o_len_q    <= '0;
			o_last_q   <= 1'b1;
			o_status_q <= csrs_pkg::ST_OK;
		end else if (cmd.emit_err) begin
			o_sidx_q   <= '0;
			o_local_q  <= '0;
			o_dest_q   <= done;
			o_len_q    <= len_q - done;
			o_last_q   <= 1'b1;
			o_status_q <= csrs_pkg::ST_BEYOND;
		end else if (cmd.seg_step && stat.seg_nonempty) begin
			o_sidx_q   <= csrs_pkg::SIDX_W'(idx_q);
			o_local_q  <= a_q - prev_q;
			o_dest_q   <= LW'(a_q - pos_q);
			o_len_q    <= LW'(b_q - a_q);
			o_last_q   <= seg_last_q;
			o_status_q <= csrs_pkg::ST_OK;
		end
	end

	assign out_valid  = o_valid_q;
	assign seg_data   = {{csrs_pkg::OUT_PAD_W{1'b0}}, o_len_q, o_dest_q, o_local_q, o_sidx_q};
	assign out_last   = o_last_q;
	assign out_status = o_status_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> stat.out_free)
		else $error("output register loaded while a result is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_STREAMS))
		else $error("range count beyond table depth");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> (o_last_q && o_status_q == csrs_pkg::ST_BEYOND))
		else $error("error result not marked last");

endmodule

/* rtl/concat_stream_read_splitter.sv */
// Top level: presents appended source streams as one stream and splits reads into segments.
//
//  channel  | dir | tdata                                  | tuser      | tlast
//  s_axis   | in  | stream_size, read_pos, read_len        | op         | -
//  m_axis   | out | stream_index, local_offset, dest_offset,| status     | last
//           |     | segment_length                          |            |
//
// One request at a time. Clear: capture, decode. Append, full table or zero-length read:
// capture, decode, result once the output is free. Read: capture, decode, per range a table
// read, clip and segment step; the scan ends at the range with the last byte or in an error.
// Reset clears the range count, the total and the output valid flag; table contents
// need no clearing. A stalled output holds the scan in place.
module concat_stream_read_splitter #(
	parameter int MAX_STREAMS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [47:0] stream_size, [95:48] read_pos, [127:96] read_len
	input  logic [csrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] op
	input  logic [csrs_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [3:0] stream_index, [51:4] local_offset, [83:52] dest_offset,
	// [115:84] segment_length, [119:116] zero
	output logic [csrs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	// [1:0] status
	output logic [csrs_pkg::STATUS_W-1:0]       m_axis_tuser
);

	localparam int SZ = csrs_pkg::SIZE_W;
	localparam int PW = csrs_pkg::POS_W;
	localparam int LW = csrs_pkg::LEN_W;

	csrs_pkg::csrs_cmd_t  cmd;
	csrs_pkg::csrs_stat_t stat;

	logic [SZ-1:0] in_stream_size;
	logic [PW-1:0] in_read_pos;
	logic [LW-1:0] in_read_len;

	assign in_stream_size = s_axis_tdata[SZ-1:0];
	assign in_read_pos    = s_axis_tdata[SZ+PW-1:SZ];
	assign in_read_len    = s_axis_tdata[SZ+PW+LW-1:SZ+PW];

	csrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	csrs_dpath #(
		.MAX_STREAMS (MAX_STREAMS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_op          (s_axis_tuser),
		.in_stream_size (in_stream_size),
		.in_read_pos    (in_read_pos),
		.in_read_len    (in_read_len),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.seg_data       (m_axis_tdata),
		.out_last       (m_axis_tlast),
		.out_status     (m_axis_tuser)
	);

endmodule
